>>> hw/rtl/swrl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrl_pkg
// Shared types, constants and elaboration helpers for the sliding window
// rate limiter.
// ----------------------------------------------------------------------------
package swrl_pkg;

  localparam int STAMP_W    = 32;
  localparam int CMD_W      = 2;
  localparam int LIMIT_W    = 11;
  localparam int BURST_W    = 7;
  localparam int REPORT_W   = 7;
  localparam int TOTAL_W    = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;
  localparam int TREE_RADIX = 8;

  localparam logic [LIMIT_W-1:0] PER_SECOND_LIMIT_RST = 11'd10;
  localparam logic [BURST_W-1:0] BURST_LIMIT_RST      = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    CMD_CHECK  = 2'd0,
    CMD_RECORD = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PER_SECOND_LIMIT = 1'd0,
    CFG_BURST_LIMIT      = 1'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DROP,
    ST_ACT,
    ST_COUNT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [STAMP_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic                allowed;
    logic [REPORT_W-1:0] count_short_window;
    logic [REPORT_W-1:0] count_long_window;
    logic                limited;
    logic [REPORT_W-1:0] stored_entries;
    logic [TOTAL_W-1:0]  total_recorded;
    logic                overflow;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_wr_t;

  typedef struct packed {
    logic shift;
    logic drop;
    logic clear;
  } cell_ctrl_t;

  function automatic int pow8(input int e);
    int r;
    r = 1;
    for (int i = 0; i < e; i++) begin
      r = r * TREE_RADIX;
    end
    return r;
  endfunction

  function automatic int tree_levels(input int n);
    int lv;
    int cap;
    lv  = 1;
    cap = TREE_RADIX;
    while (cap < n) begin
      lv  = lv + 1;
      cap = cap * TREE_RADIX;
    end
    return lv;
  endfunction

  function automatic int level_base(input int levels, input int lvl);
    int base;
    base = 0;
    for (int j = 1; j < lvl; j++) begin
      base = base + pow8(levels - j);
    end
    return base;
  endfunction

endpackage

>>> hw/rtl/swrl_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrl_chan_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface swrl_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/sliding_window_rate_limiter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_rate_limiter
// Sliding-window-log rate limiter built on a chain of timestamp cells.
// ----------------------------------------------------------------------------
// Each item on req carries a command (check, record, clear) and the current
// time in ms; exactly one result comes back on resp per item, in order. Stamps
// live in a chain of DEPTH cells, newest at the head; a record shifts the
// chain by one, a check drops the oldest out-of-window stamp once per cycle.
// Window counts come from a registered radix-8 counting tree with L levels,
// L = ceil(log8(DEPTH)), 2 at the default depth. An item passes the states
// IDLE, DROP (check) or ACT (record, clear), COUNT and DONE; a check stays
// in DROP while it drops stamps. The resp register holds a finished result
// while the next item is taken. Configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
module sliding_window_rate_limiter import swrl_pkg::*; #(
  parameter int DEPTH           = 64,
  parameter int SHORT_WINDOW_MS = 1000,
  parameter int LONG_WINDOW_MS  = 60000
) (
  input  logic         clk,
  input  logic         rst,
  swrl_chan_if.sink    req,
  swrl_chan_if.source  resp,
  swrl_chan_if.sink    cfg
);

  localparam int CW  = $clog2(DEPTH + 1);
  localparam int LAT = tree_levels(DEPTH);
  localparam int LW  = $clog2(LAT + 1);

  state_t               state, state_next;
  logic [CMD_W-1:0]     cmd;
  logic [STAMP_W-1:0]   stamp_now;
  logic [CW-1:0]        count;
  logic [TOTAL_W-1:0]   total;
  logic                 overflow;
  logic [LW-1:0]        wait_cnt;
  logic [LIMIT_W-1:0]   per_second_limit;
  logic [BURST_W-1:0]   burst_limit;
  logic                 out_valid;
  out_item_t            out_data;

  cell_ctrl_t           ctrl;
  logic [STAMP_W-1:0]   cell_stamp [DEPTH];
  logic [DEPTH-1:0]     cell_valid;
  logic [DEPTH-1:0]     young_short;
  logic [DEPTH-1:0]     young_long;
  logic [DEPTH-1:0]     tail_old;
  logic [CW-1:0]        short_cnt;
  logic [CW-1:0]        long_cnt;

  logic                 full;
  logic                 any_tail;
  logic                 req_fire;
  logic                 resp_free;
  logic                 do_record;
  logic                 allowed;

  assign full      = (count == CW'(DEPTH));
  assign any_tail  = |tail_old;
  assign req_fire  = req.valid && req.ready;
  assign resp_free = !out_valid || resp.ready;
  assign do_record = (cmd == CMD_RECORD) && !full;
  assign allowed   = (cmd == CMD_CHECK) &&
                     (32'(count) < 32'(burst_limit)) &&
                     (32'(short_cnt) < 32'(per_second_limit));

  assign cfg.ready  = 1'b1;
  assign resp.valid = out_valid;
  assign resp.data  = out_data;

  // cell chain, newest stamp enters at cell 0
  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic [STAMP_W-1:0] prev_stamp;
      logic               prev_valid;
      logic               next_valid;
      if (i == 0) begin : g_head
        assign prev_stamp = stamp_now;
        assign prev_valid = 1'b1;
      end else begin : g_body
        assign prev_stamp = cell_stamp[i-1];
        assign prev_valid = cell_valid[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
        assign next_valid = 1'b0;
      end else begin : g_link
        assign next_valid = cell_valid[i+1];
      end
      swrl_cell #(
        .SHORT_WINDOW_MS (SHORT_WINDOW_MS),
        .LONG_WINDOW_MS  (LONG_WINDOW_MS)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .now_ms      (stamp_now),
        .prev_stamp  (prev_stamp),
        .prev_valid  (prev_valid),
        .next_valid  (next_valid),
        .stamp       (cell_stamp[i]),
        .valid       (cell_valid[i]),
        .young_short (young_short[i]),
        .young_long  (young_long[i]),
        .tail_old    (tail_old[i])
      );
    end
  endgenerate

  swrl_count_tree #(.N(DEPTH), .CW(CW)) u_short_tree (
    .clk   (clk),
    .flags (young_short),
    .total (short_cnt)
  );

  swrl_count_tree #(.N(DEPTH), .CW(CW)) u_long_tree (
    .clk   (clk),
    .flags (young_long),
    .total (long_cnt)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = (req.data.cmd == CMD_CHECK) ? ST_DROP : ST_ACT;
        end
      end
      ST_DROP: begin
        if (!any_tail) begin
          state_next = ST_COUNT;
        end
      end
      ST_ACT: begin
        state_next = ST_COUNT;
      end
      ST_COUNT: begin
        if (wait_cnt == LW'(LAT - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (resp_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready  = 1'b0;
    ctrl       = '0;
    case (state)
      ST_IDLE: req.ready  = 1'b1;
      ST_DROP: ctrl.drop  = 1'b1;
      ST_ACT: begin
        ctrl.shift = do_record;
        ctrl.clear = (cmd == CMD_CLEAR);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      count            <= '0;
      total            <= '0;
      wait_cnt         <= '0;
      out_valid        <= 1'b0;
      per_second_limit <= PER_SECOND_LIMIT_RST;
      burst_limit      <= BURST_LIMIT_RST;
    end else begin
      state <= state_next;

      if (state == ST_COUNT) begin
        wait_cnt <= wait_cnt + LW'(1);
      end else begin
        wait_cnt <= '0;
      end

      if (state == ST_DROP && any_tail) begin
        count <= count - CW'(1);
      end else if (state == ST_ACT && do_record) begin
        count <= count + CW'(1);
      end else if (state == ST_ACT && cmd == CMD_CLEAR) begin
        count <= '0;
      end

      if (state == ST_ACT && do_record && total != '1) begin
        total <= total + TOTAL_W'(1);
      end else if (state == ST_ACT && cmd == CMD_CLEAR) begin
        total <= '0;
      end

      if (state == ST_DONE && resp_free) begin
        out_valid <= 1'b1;
      end else if (resp.ready) begin
        out_valid <= 1'b0;
      end

      if (cfg.valid) begin
        case (cfg.data.index)
          CFG_PER_SECOND_LIMIT: per_second_limit <= cfg.data.value;
          CFG_BURST_LIMIT:      burst_limit      <= cfg.data.value[BURST_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      cmd       <= req.data.cmd;
      stamp_now <= req.data.now_ms;
      overflow  <= 1'b0;
    end else if (state == ST_ACT && cmd == CMD_RECORD && full) begin
      overflow  <= 1'b1;
    end

    if (state == ST_DONE && resp_free) begin
      out_data.allowed            <= allowed;
      out_data.count_short_window <= REPORT_W'(short_cnt);
      out_data.count_long_window  <= REPORT_W'(long_cnt);
      out_data.limited            <= (32'(short_cnt) >= 32'(per_second_limit));
      out_data.stored_entries     <= REPORT_W'(count);
      out_data.total_recorded     <= total;
      out_data.overflow           <= overflow;
    end
  end

endmodule

>>> hw/rtl/swrl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrl_cell
// One slot of the timestamp chain: holds a stamp, shifts toward the older
// end on a record, drops itself when it is the oldest and out of window.
// ----------------------------------------------------------------------------
module swrl_cell import swrl_pkg::*; #(
  parameter int SHORT_WINDOW_MS = 1000,
  parameter int LONG_WINDOW_MS  = 60000
) (
  input  logic               clk,
  input  logic               rst,
  input  cell_ctrl_t         ctrl,
  input  logic [STAMP_W-1:0] now_ms,
  input  logic [STAMP_W-1:0] prev_stamp,
  input  logic               prev_valid,
  input  logic               next_valid,
  output logic [STAMP_W-1:0] stamp,
  output logic               valid,
  output logic               young_short,
  output logic               young_long,
  output logic               tail_old
);

  logic [STAMP_W-1:0] age;

  assign age         = now_ms - stamp;
  assign young_short = valid && (age < STAMP_W'(SHORT_WINDOW_MS));
  assign young_long  = valid && (age < STAMP_W'(LONG_WINDOW_MS));
  assign tail_old    = valid && !next_valid && (age > STAMP_W'(LONG_WINDOW_MS));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.clear) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= prev_valid;
    end else if (ctrl.drop && tail_old) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      stamp <= prev_stamp;
    end
  end

endmodule

>>> hw/rtl/swrl_count_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrl_count_tree
// Registered radix-8 population count over the cell flags, one register
// level per tree level.
// ----------------------------------------------------------------------------
module swrl_count_tree import swrl_pkg::*; #(
  parameter int N  = 64,
  parameter int CW = 7
) (
  input  logic          clk,
  input  logic [N-1:0]  flags,
  output logic [CW-1:0] total
);

  localparam int LEVELS = tree_levels(N);
  localparam int LEAVES = pow8(LEVELS);
  localparam int NODES  = level_base(LEVELS, LEVELS + 1);

  logic [LEAVES-1:0] leaf;
  logic [CW-1:0]     node [NODES];

  always_comb begin
    leaf        = '0;
    leaf[N-1:0] = flags;
  end

  genvar l, n;
  generate
    for (l = 1; l <= LEVELS; l++) begin : g_level
      for (n = 0; n < pow8(LEVELS - l); n++) begin : g_node
        logic [CW-1:0] sum;
        if (l == 1) begin : g_leaf
          always_comb begin
            sum = '0;
            for (int k = 0; k < TREE_RADIX; k++) begin
              sum = sum + CW'(leaf[TREE_RADIX*n + k]);
            end
          end
        end else begin : g_inner
          always_comb begin
            sum = '0;
            for (int k = 0; k < TREE_RADIX; k++) begin
              sum = sum + node[level_base(LEVELS, l - 1) + TREE_RADIX*n + k];
            end
          end
        end
        always_ff @(posedge clk) begin
          node[level_base(LEVELS, l) + n] <= sum;
        end
      end
    end
  endgenerate

  assign total = node[level_base(LEVELS, LEVELS)];

endmodule

>>> hw/rtl/swrl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swrl_checker
// Port-level checks for the rate limiter, bound to the top level.
// ----------------------------------------------------------------------------
module swrl_checker import swrl_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_ready,
  input logic      resp_valid,
  input logic      resp_ready,
  input out_item_t resp_data
);

  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp_ready |=> resp_valid)
    else $error("resp valid dropped while stalled");

  a_resp_stable: assert property (@(posedge clk) disable iff (rst)
    resp_valid && !resp_ready |=> $stable(resp_data))
    else $error("resp item changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second item taken while one is in work");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(resp_valid) |-> !$past(req_ready))
    else $error("result appeared without an item in work");

  a_allowed_clean: assert property (@(posedge clk) disable iff (rst)
    resp_valid |-> !(resp_data.allowed && (resp_data.limited || resp_data.overflow)))
    else $error("allowed item reports limited or overflow");

endmodule

bind sliding_window_rate_limiter swrl_checker u_swrl_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .resp_valid (resp.valid),
  .resp_ready (resp.ready),
  .resp_data  (resp.data)
);
